// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define DIMU_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("dimu check failed");

// condition holds in the next cycle
`define DIMU_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("dimu check failed");

`endif

// ===== rtl/core/dimu_pkg.sv =====
package dimu_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int ELAPSED_W = 20;
	localparam int ANGLE_W   = 32;
	localparam int WEIGHT_W  = 17;
	localparam int NOW_W     = 25;
	localparam int MUL_A_W   = 34;
	localparam int MUL_B_W   = 21;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int DIV_W     = 20;
	localparam int QUO_W     = 32;
	localparam int CNT_W     = 4;
	localparam int PC_W      = 5;
	localparam int IDX_W     = 3;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
	localparam logic [DIV_W-1:0]    US_PER_S   = 20'd1000000;
	localparam logic [DIV_W-1:0]    HALF_S     = 20'd500000;

	localparam logic signed [SAMPLE_W-1:0] RST_ACCEL_OFS_FIRST  = -16'sd480;
	localparam logic signed [SAMPLE_W-1:0] RST_ACCEL_OFS_SECOND = 16'sd8910;
	localparam logic signed [SAMPLE_W-1:0] RST_GYRO_OFS_FIRST   = -16'sd440;
	localparam logic signed [SAMPLE_W-1:0] RST_GYRO_OFS_SECOND  = 16'sd1172;
	localparam logic [WEIGHT_W-1:0]        RST_SMOOTH_WEIGHT    = 17'd26214;
	localparam logic [WEIGHT_W-1:0]        RST_FUSION_WEIGHT    = 17'd64225;

	typedef enum logic [IDX_W-1:0] {
		REG_ACCEL_OFS_FIRST  = 3'd0,
		REG_ACCEL_OFS_SECOND = 3'd1,
		REG_GYRO_OFS_FIRST   = 3'd2,
		REG_GYRO_OFS_SECOND  = 3'd3,
		REG_SMOOTH_WEIGHT    = 3'd4,
		REG_FUSION_WEIGHT    = 3'd5
	} reg_idx_t;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_WAIT     = 5'd0;
	localparam pc_t PC_SA_OLD   = 5'd1;
	localparam pc_t PC_SA_NEW   = 5'd2;
	localparam pc_t PC_SG_OLD   = 5'd3;
	localparam pc_t PC_SG_NEW   = 5'd4;
	localparam pc_t PC_SG_SUM   = 5'd5;
	localparam pc_t PC_SG_WB    = 5'd6;
	localparam pc_t PC_RATE     = 5'd7;
	localparam pc_t PC_RATE_ACC = 5'd8;
	localparam pc_t PC_DIV_PREP = 5'd9;
	localparam pc_t PC_DIV      = 5'd10;
	localparam pc_t PC_INTEG    = 5'd11;
	localparam pc_t PC_FA_GYRO  = 5'd12;
	localparam pc_t PC_FA_ACCEL = 5'd13;
	localparam pc_t PC_FA_SUM   = 5'd14;
	localparam pc_t PC_FA_WB    = 5'd15;
	localparam pc_t PC_OUT      = 5'd16;

	typedef enum logic [2:0] {
		A_SA, A_ACC_NOW, A_SG, A_GYR_NOW, A_T
	} mul_a_t;

	typedef enum logic [2:0] {
		B_ALPHA_C, B_ALPHA, B_ELAPSED, B_BETA, B_BETA_C
	} mul_b_t;

	typedef enum logic [1:0] {
		ACC_NONE, ACC_LOAD, ACC_LOAD_RND, ACC_ADD
	} acc_op_t;

	typedef enum logic [2:0] {
		WB_NONE, WB_SA, WB_SG, WB_FA, WB_DIV_PREP, WB_T
	} wb_t;

	typedef enum logic [1:0] {
		BR_NEXT, BR_ACCEPT, BR_LOOP, BR_OUT
	} br_t;

	typedef struct packed {
		mul_a_t  a_sel;
		mul_b_t  b_sel;
		logic    mul_en;
		acc_op_t acc_op;
		wb_t     wb;
		br_t     br;
		pc_t     target;
	} uop_t;

	function automatic uop_t ucode(input pc_t pc);
		uop_t u;
		u = '{A_SA, B_ALPHA_C, 1'b0, ACC_NONE, WB_NONE, BR_NEXT, PC_WAIT};
		unique case (pc)
			PC_WAIT:     u = '{A_SA, B_ALPHA_C, 1'b0, ACC_NONE, WB_NONE, BR_ACCEPT, PC_OUT};
			PC_SA_OLD:   u = '{A_SA, B_ALPHA_C, 1'b1, ACC_NONE, WB_NONE, BR_NEXT, PC_WAIT};
			PC_SA_NEW:   u = '{A_ACC_NOW, B_ALPHA, 1'b1, ACC_LOAD, WB_NONE, BR_NEXT, PC_WAIT};
			PC_SG_OLD:   u = '{A_SG, B_ALPHA_C, 1'b1, ACC_ADD, WB_NONE, BR_NEXT, PC_WAIT};
			PC_SG_NEW:   u = '{A_GYR_NOW, B_ALPHA, 1'b1, ACC_LOAD, WB_SA, BR_NEXT, PC_WAIT};
			PC_SG_SUM:   u = '{A_SG, B_ALPHA, 1'b0, ACC_ADD, WB_NONE, BR_NEXT, PC_WAIT};
			PC_SG_WB:    u = '{A_SG, B_ALPHA, 1'b0, ACC_NONE, WB_SG, BR_NEXT, PC_WAIT};
			PC_RATE:     u = '{A_SG, B_ELAPSED, 1'b1, ACC_NONE, WB_NONE, BR_NEXT, PC_WAIT};
			PC_RATE_ACC: u = '{A_SG, B_ELAPSED, 1'b0, ACC_LOAD_RND, WB_NONE, BR_NEXT, PC_WAIT};
			PC_DIV_PREP: u = '{A_SG, B_ELAPSED, 1'b0, ACC_NONE, WB_DIV_PREP, BR_NEXT, PC_WAIT};
			PC_DIV:      u = '{A_SG, B_ELAPSED, 1'b0, ACC_NONE, WB_NONE, BR_LOOP, PC_WAIT};
			PC_INTEG:    u = '{A_T, B_BETA, 1'b0, ACC_NONE, WB_T, BR_NEXT, PC_WAIT};
			PC_FA_GYRO:  u = '{A_T, B_BETA, 1'b1, ACC_NONE, WB_NONE, BR_NEXT, PC_WAIT};
			PC_FA_ACCEL: u = '{A_SA, B_BETA_C, 1'b1, ACC_LOAD, WB_NONE, BR_NEXT, PC_WAIT};
			PC_FA_SUM:   u = '{A_SA, B_BETA_C, 1'b0, ACC_ADD, WB_NONE, BR_NEXT, PC_WAIT};
			PC_FA_WB:    u = '{A_SA, B_BETA_C, 1'b0, ACC_NONE, WB_FA, BR_NEXT, PC_WAIT};
			PC_OUT:      u = '{A_SA, B_BETA_C, 1'b0, ACC_NONE, WB_NONE, BR_OUT, PC_WAIT};
			default:     u = '{A_SA, B_ALPHA_C, 1'b0, ACC_NONE, WB_NONE, BR_OUT, PC_WAIT};
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/core/dimu_if.sv =====
interface dimu_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [dimu_pkg::SAMPLE_W-1:0]  accel_first;
	logic signed [dimu_pkg::SAMPLE_W-1:0]  accel_second;
	logic signed [dimu_pkg::SAMPLE_W-1:0]  gyro_first;
	logic signed [dimu_pkg::SAMPLE_W-1:0]  gyro_second;
	logic        [dimu_pkg::ELAPSED_W-1:0] elapsed_us;

	modport source (
		output valid, accel_first, accel_second, gyro_first, gyro_second, elapsed_us,
		input  ready
	);
	modport sink (
		input  valid, accel_first, accel_second, gyro_first, gyro_second, elapsed_us,
		output ready
	);
endinterface

interface dimu_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [dimu_pkg::ANGLE_W-1:0] tilt_angle;
	logic signed [dimu_pkg::ANGLE_W-1:0] filtered_accel;
	logic signed [dimu_pkg::ANGLE_W-1:0] filtered_gyro;
	logic                                no_time;

	modport source (
		output valid, tilt_angle, filtered_accel, filtered_gyro, no_time,
		input  ready
	);
	modport sink (
		input  valid, tilt_angle, filtered_accel, filtered_gyro, no_time,
		output ready
	);
endinterface

// ===== rtl/core/dual_imu_tilt_fusion.sv =====
// channel  | dir | payload                                                 | handshake
// sample   | in  | accel_first/second, gyro_first/second, elapsed_us       | valid/ready
// result   | out | tilt_angle, filtered_accel, filtered_gyro, no_time      | valid/ready
// cfg      | in  | cfg_index, cfg_wdata                                    | cfg_wr_en
//
// one item at a time, taken in PC_WAIT only, as set by the microcode program
// on the shared 34x21 multiplier and the 16-step radix-4 divide by 1e6 for gyro*dt
// an item with zero elapsed time skips the program and goes straight to PC_OUT
// a pending result is held in the output register, the next item is taken meanwhile
// reset restores the register defaults and clears the filter state, no clearing pass
`include "assert_macros.svh"

module dual_imu_tilt_fusion (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dimu_pkg::IDX_W-1:0]        cfg_index,
	input  logic [dimu_pkg::WEIGHT_W-1:0]     cfg_wdata,
	dimu_in_if.sink                           sample,
	dimu_out_if.source                        result
);

	localparam int SW = dimu_pkg::SAMPLE_W;
	localparam int AW = dimu_pkg::ANGLE_W;
	localparam int WW = dimu_pkg::WEIGHT_W;
	localparam int NW = dimu_pkg::NOW_W;
	localparam int MA = dimu_pkg::MUL_A_W;
	localparam int MB = dimu_pkg::MUL_B_W;
	localparam int PW = dimu_pkg::PROD_W;
	localparam int CW = dimu_pkg::ACC_W;
	localparam int DW = dimu_pkg::DIV_W;
	localparam int QW = dimu_pkg::QUO_W;

	// configuration
	logic signed [SW-1:0] accel_ofs_first_q, accel_ofs_second_q;
	logic signed [SW-1:0] gyro_ofs_first_q, gyro_ofs_second_q;
	logic [WW-1:0]        smooth_weight_q, fusion_weight_q;

	// filter state
	logic signed [AW-1:0] smooth_accel_q, smooth_gyro_q, fused_angle_q;

	// sequencer
	dimu_pkg::pc_t                 pc_q, pc_d;
	dimu_pkg::uop_t                uop;
	logic [dimu_pkg::CNT_W-1:0]    cnt_q;

	// datapath
	logic signed [NW-1:0]          acc_now_q, gyr_now_q;
	logic [dimu_pkg::ELAPSED_W-1:0] elapsed_q;
	logic                          no_time_q;
	logic signed [PW-1:0]          prod_q;
	logic signed [CW-1:0]          acc_q;
	logic [DW-1:0]                 rem_q;
	logic [QW-1:0]                 quo_q;
	logic                          neg_q;
	logic signed [MA-1:0]          t_q;

	// result register
	logic                          out_valid_q;
	logic signed [AW-1:0]          out_tilt_q, out_accel_q, out_gyro_q;
	logic                          out_no_time_q;

	logic                 accept, out_ok;
	logic [WW-1:0]        alpha, alpha_c, beta, beta_c;
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] prod_d;
	logic signed [CW-1:0] prod_ext;
	logic signed [AW-1:0] acc_round;
	logic signed [CW-1:0] div_n;
	logic [DW:0]          dr1, dr2;
	logic [DW-1:0]        dr1s, dr2s;
	logic                 dq1, dq2;

	function automatic logic signed [NW-1:0] pair_deg(
		input logic signed [SW-1:0] r1,
		input logic signed [SW-1:0] o1,
		input logic signed [SW-1:0] r2,
		input logic signed [SW-1:0] o2
	);
		logic signed [SW-1:0] v1, v2;
		logic signed [SW:0]   s;
		logic signed [NW-1:0] se;
		v1 = r1 + o1;
		v2 = r2 + o2;
		s  = $signed({v1[SW-1], v1}) + $signed({v2[SW-1], v2});
		se = $signed({{(NW-SW-1){s[SW]}}, s});
		return -(se * 25'sd180);
	endfunction

	// round to nearest, ties up, back to q15.16 and saturate
	function automatic logic signed [AW-1:0] round_sat(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		logic [CW-17:0]       q;
		r = v + $signed({{(CW-16){1'b0}}, 16'h8000});
		q = r[CW-1:16];
		if (!q[CW-17] && (|q[CW-18:AW-1]))
			return {1'b0, {(AW-1){1'b1}}};
		else if (q[CW-17] && !(&q[CW-18:AW-1]))
			return {1'b1, {(AW-1){1'b0}}};
		else
			return q[AW-1:0];
	endfunction

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (pc_q == dimu_pkg::PC_WAIT);
	assign out_ok       = !out_valid_q || result.ready;

	assign alpha   = smooth_weight_q[WW-1] ? dimu_pkg::WEIGHT_ONE : smooth_weight_q;
	assign alpha_c = dimu_pkg::WEIGHT_ONE - alpha;
	assign beta    = fusion_weight_q[WW-1] ? dimu_pkg::WEIGHT_ONE : fusion_weight_q;
	assign beta_c  = dimu_pkg::WEIGHT_ONE - beta;

	assign uop = dimu_pkg::ucode(pc_q);

	always_comb begin
		case (uop.a_sel)
			dimu_pkg::A_SA:      mul_a = $signed({{(MA-AW){smooth_accel_q[AW-1]}}, smooth_accel_q});
			dimu_pkg::A_ACC_NOW: mul_a = $signed({{(MA-NW){acc_now_q[NW-1]}}, acc_now_q});
			dimu_pkg::A_SG:      mul_a = $signed({{(MA-AW){smooth_gyro_q[AW-1]}}, smooth_gyro_q});
			dimu_pkg::A_GYR_NOW: mul_a = $signed({{(MA-NW){gyr_now_q[NW-1]}}, gyr_now_q});
			default:             mul_a = t_q;
		endcase
		case (uop.b_sel)
			dimu_pkg::B_ALPHA_C: mul_b = $signed({{(MB-WW){1'b0}}, alpha_c});
			dimu_pkg::B_ALPHA:   mul_b = $signed({{(MB-WW){1'b0}}, alpha});
			dimu_pkg::B_ELAPSED: mul_b = $signed({{(MB-dimu_pkg::ELAPSED_W){1'b0}}, elapsed_q});
			dimu_pkg::B_BETA:    mul_b = $signed({{(MB-WW){1'b0}}, beta});
			default:             mul_b = $signed({{(MB-WW){1'b0}}, beta_c});
		endcase
	end

	assign prod_d    = mul_a * mul_b;
	assign prod_ext  = $signed({prod_q[PW-1], prod_q});
	assign acc_round = round_sat(acc_q);

	// floor division of a negative value: -((~v + d) / d)
	assign div_n = acc_q[CW-1]
		? (~acc_q) + $signed({{(CW-DW){1'b0}}, dimu_pkg::US_PER_S})
		: acc_q;

	// two quotient bits per cycle
	always_comb begin
		dr1  = {rem_q, quo_q[QW-1]};
		dq1  = (dr1 >= {1'b0, dimu_pkg::US_PER_S});
		dr1s = dq1 ? DW'(dr1 - {1'b0, dimu_pkg::US_PER_S}) : dr1[DW-1:0];
		dr2  = {dr1s, quo_q[QW-2]};
		dq2  = (dr2 >= {1'b0, dimu_pkg::US_PER_S});
		dr2s = dq2 ? DW'(dr2 - {1'b0, dimu_pkg::US_PER_S}) : dr2[DW-1:0];
	end

	always_comb begin
		pc_d = pc_q;
		unique case (uop.br)
			dimu_pkg::BR_NEXT: pc_d = pc_q + 5'd1;
			dimu_pkg::BR_ACCEPT: begin
				if (accept)
					pc_d = (sample.elapsed_us == '0) ? uop.target : pc_q + 5'd1;
			end
			dimu_pkg::BR_LOOP: begin
				if (cnt_q == '1)
					pc_d = pc_q + 5'd1;
			end
			dimu_pkg::BR_OUT: begin
				if (out_ok)
					pc_d = uop.target;
			end
			default: pc_d = dimu_pkg::PC_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= dimu_pkg::PC_WAIT;
			cnt_q <= '0;
		end else begin
			pc_q <= pc_d;
			if (uop.br == dimu_pkg::BR_LOOP)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_ofs_first_q  <= dimu_pkg::RST_ACCEL_OFS_FIRST;
			accel_ofs_second_q <= dimu_pkg::RST_ACCEL_OFS_SECOND;
			gyro_ofs_first_q   <= dimu_pkg::RST_GYRO_OFS_FIRST;
			gyro_ofs_second_q  <= dimu_pkg::RST_GYRO_OFS_SECOND;
			smooth_weight_q    <= dimu_pkg::RST_SMOOTH_WEIGHT;
			fusion_weight_q    <= dimu_pkg::RST_FUSION_WEIGHT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dimu_pkg::REG_ACCEL_OFS_FIRST:  accel_ofs_first_q  <= cfg_wdata[SW-1:0];
				dimu_pkg::REG_ACCEL_OFS_SECOND: accel_ofs_second_q <= cfg_wdata[SW-1:0];
				dimu_pkg::REG_GYRO_OFS_FIRST:   gyro_ofs_first_q   <= cfg_wdata[SW-1:0];
				dimu_pkg::REG_GYRO_OFS_SECOND:  gyro_ofs_second_q  <= cfg_wdata[SW-1:0];
				dimu_pkg::REG_SMOOTH_WEIGHT:    smooth_weight_q    <= cfg_wdata;
				dimu_pkg::REG_FUSION_WEIGHT:    fusion_weight_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_accel_q <= '0;
			smooth_gyro_q  <= '0;
			fused_angle_q  <= '0;
		end else begin
			case (uop.wb)
				dimu_pkg::WB_SA: smooth_accel_q <= acc_round;
				dimu_pkg::WB_SG: smooth_gyro_q  <= acc_round;
				dimu_pkg::WB_FA: fused_angle_q  <= acc_round;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_now_q <= pair_deg(sample.accel_first, accel_ofs_first_q,
				sample.accel_second, accel_ofs_second_q);
			gyr_now_q <= pair_deg(sample.gyro_first, gyro_ofs_first_q,
				sample.gyro_second, gyro_ofs_second_q);
			elapsed_q <= sample.elapsed_us;
			no_time_q <= (sample.elapsed_us == '0);
		end
		if (uop.mul_en)
			prod_q <= prod_d;
		case (uop.acc_op)
			dimu_pkg::ACC_LOAD:     acc_q <= prod_ext;
			dimu_pkg::ACC_LOAD_RND: acc_q <= prod_ext
				+ $signed({{(CW-DW){1'b0}}, dimu_pkg::HALF_S});
			dimu_pkg::ACC_ADD:      acc_q <= acc_q + prod_ext;
			default: ;
		endcase
		case (uop.wb)
			dimu_pkg::WB_DIV_PREP: begin
				neg_q <= acc_q[CW-1];
				rem_q <= div_n[DW+QW-1:QW];
				quo_q <= div_n[QW-1:0];
			end
			dimu_pkg::WB_T: begin
				if (neg_q)
					t_q <= $signed({{(MA-AW){fused_angle_q[AW-1]}}, fused_angle_q})
						- $signed({{(MA-QW){1'b0}}, quo_q});
				else
					t_q <= $signed({{(MA-AW){fused_angle_q[AW-1]}}, fused_angle_q})
						+ $signed({{(MA-QW){1'b0}}, quo_q});
			end
			default: ;
		endcase
		if (uop.br == dimu_pkg::BR_LOOP) begin
			rem_q <= dr2s;
			quo_q <= {quo_q[QW-3:0], dq1, dq2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uop.br == dimu_pkg::BR_OUT && out_ok) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uop.br == dimu_pkg::BR_OUT && out_ok) begin
			out_tilt_q    <= no_time_q ? '0 : fused_angle_q;
			out_accel_q   <= no_time_q ? '0 : smooth_accel_q;
			out_gyro_q    <= no_time_q ? '0 : smooth_gyro_q;
			out_no_time_q <= no_time_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.tilt_angle     = out_tilt_q;
	assign result.filtered_accel = out_accel_q;
	assign result.filtered_gyro  = out_gyro_q;
	assign result.no_time        = out_no_time_q;

	`DIMU_NEXT(a_zero_time_skips, clk, arst_n, accept && sample.elapsed_us == '0,
		pc_q == dimu_pkg::PC_OUT)
	`DIMU_IMPLIES(a_cnt_idle, clk, arst_n, pc_q != dimu_pkg::PC_DIV, cnt_q == '0)
	`DIMU_IMPLIES(a_no_time_zero, clk, arst_n, result.valid && result.no_time,
		result.tilt_angle == '0 && result.filtered_accel == '0 && result.filtered_gyro == '0)
	`DIMU_NEXT(a_out_holds, clk, arst_n,
		pc_q == dimu_pkg::PC_OUT && out_valid_q && !result.ready, pc_q == dimu_pkg::PC_OUT)

endmodule
